// ===== hw/rtl/htc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package htc_pkg;

	localparam int WINDOW_DEPTH = 5;
	localparam int SPIKE_LIMIT  = 20;

	// With the low two bits dropped (u = raw >> 2), the temperature numerator over
	// TEMP_UNIT is TEMP_SLOPE*u - 4096*(TEMP_ZERO + offset).
	localparam int TEMP_SLOPE = 4393;
	localparam int TEMP_ZERO  = 4685;
	localparam int TEMP_UNIT  = 409600;
	localparam int TEMP_GATE  = SPIKE_LIMIT * TEMP_UNIT;

	// The humidity numerator over 2^14 is |HUM_SLOPE*u - HUM_ZERO|.
	localparam int HUM_SLOPE = 125;
	localparam int HUM_ZERO  = 49152;
	localparam int HUM_GATE  = SPIKE_LIMIT * 16384;

	// Exact floor division by 25 for 13-bit operands.
	localparam int DIV25_SHIFT = 20;
	localparam int DIV25_RECIP = (2 ** DIV25_SHIFT + 24) / 25;

	// Window sum and its floor division by the depth.
	localparam int SUM_W       = 10 + $clog2(WINDOW_DEPTH);
	localparam int MEAN_SHIFT  = 20;
	localparam int MEAN_RECIP  = (2 ** MEAN_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH;

	localparam int TEMP_HI     = 100;
	localparam int TEMP_LO     = -20;
	localparam int TEMP_KNEE   = 120;
	localparam int HUMID_HI    = 100;
	localparam int BIAS_BASE   = 100;

	typedef enum logic {
		OP_TEMP  = 1'b0,
		OP_HUMID = 1'b1
	} htc_op_t;

	typedef enum logic [1:0] {
		REG_TEMP_OFFSET = 2'd0,
		REG_TEMP_BIAS   = 2'd1,
		REG_HUMID_BIAS  = 2'd2
	} htc_reg_t;

	typedef struct packed {
		logic signed [10:0] temp_offset_centi;
		logic [7:0]         temp_bias;
		logic [7:0]         humid_bias;
	} htc_cfg_t;

	typedef struct packed {
		htc_op_t            op;
		logic               err;
		logic signed [27:0] temp_num;
		logic [20:0]        humid_num;
	} htc_scaled_t;

	typedef struct packed {
		htc_op_t           op;
		logic              err;
		logic              acc;
		logic signed [8:0] run_value;
	} htc_run_t;

	typedef struct packed {
		logic signed [7:0] temp_out;
		logic [6:0]        humid_out;
		logic signed [8:0] run_value;
		logic              sensor_error;
		logic              accepted;
	} htc_result_t;

	// Humidity correction trunc(2.3 + 1.04*mean) for every possible mean.
	typedef logic [255:0][8:0] htc_corr_tab_t;

	function automatic htc_corr_tab_t build_hum_corr();
		htc_corr_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = 9'((230 + 104 * i) / 100);
		end
		return tab;
	endfunction

	localparam htc_corr_tab_t HUM_CORR = build_hum_corr();

endpackage

`default_nettype wire

// ===== hw/rtl/htc_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output htc_pkg::htc_cfg_t cfg
);

	logic signed [10:0] temp_offset_q;
	logic [7:0]         temp_bias_q;
	logic [7:0]         humid_bias_q;
	logic               wr_en;
	htc_pkg::htc_reg_t  reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = htc_pkg::htc_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_offset_q <= '0;
			temp_bias_q   <= 8'(htc_pkg::BIAS_BASE);
			humid_bias_q  <= 8'(htc_pkg::BIAS_BASE);
		end else if (wr_en) begin
			case (reg_sel)
				htc_pkg::REG_TEMP_OFFSET: temp_offset_q <= pwdata[10:0];
				htc_pkg::REG_TEMP_BIAS:   temp_bias_q   <= pwdata[7:0];
				htc_pkg::REG_HUMID_BIAS:  humid_bias_q  <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			htc_pkg::REG_TEMP_OFFSET: prdata = {{21{temp_offset_q[10]}}, temp_offset_q};
			htc_pkg::REG_TEMP_BIAS:   prdata = {24'd0, temp_bias_q};
			htc_pkg::REG_HUMID_BIAS:  prdata = {24'd0, humid_bias_q};
			default:                  prdata = '0;
		endcase
	end

	assign cfg.temp_offset_centi = temp_offset_q;
	assign cfg.temp_bias         = temp_bias_q;
	assign cfg.humid_bias        = humid_bias_q;

endmodule

`default_nettype wire

// ===== hw/rtl/htc_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htc_scale (
	input  logic                  op,
	input  logic [15:0]           raw_reading,
	input  logic signed [10:0]    temp_offset_centi,
	output htc_pkg::htc_scaled_t  scaled
);

	logic [13:0]        u;
	logic signed [31:0] u_ext;
	logic signed [31:0] k_ext;
	logic signed [31:0] t_num;
	logic signed [31:0] h_num;
	logic [31:0]        h_mag;

	always_comb begin
		u     = raw_reading[15:2];
		u_ext = $signed({18'd0, u});
		k_ext = 32'(htc_pkg::TEMP_ZERO) + {{21{temp_offset_centi[10]}}, temp_offset_centi};
		t_num = u_ext * 32'(htc_pkg::TEMP_SLOPE) - (k_ext <<< 12);
		h_num = u_ext * 32'(htc_pkg::HUM_SLOPE) - 32'(htc_pkg::HUM_ZERO);
		h_mag = h_num[31] ? 32'(-h_num) : 32'(h_num);

		scaled.op        = htc_pkg::htc_op_t'(op);
		scaled.err       = (u == '0);
		scaled.temp_num  = t_num[27:0];
		scaled.humid_num = h_mag[20:0];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/htc_run_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htc_run_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  htc_pkg::htc_scaled_t scaled,
	input  logic                 upd,
	output htc_pkg::htc_run_t    run
);

	logic signed [8:0]  temp_run_q;
	logic [7:0]         humid_run_q;

	logic signed [31:0] w_ext;
	logic signed [31:0] w_prod;
	logic signed [31:0] a_ext;
	logic signed [31:0] t_diff;
	logic signed [31:0] t_sum;
	logic [31:0]        t_diff_mag;
	logic [31:0]        t_sum_mag;
	logic [31:0]        a_mag;
	logic [8:0]         qn_mag;
	logic [8:0]         q0_mag;
	logic signed [9:0]  qn;
	logic signed [9:0]  q0;
	logic signed [8:0]  t_new;
	logic               gate_t;

	logic [21:0]        h_wp;
	logic signed [23:0] h_diff;
	logic [23:0]        h_diff_mag;
	logic [22:0]        h_sum;
	logic [7:0]         h_new;
	logic               gate_h;

	function automatic logic [8:0] div25(input logic [12:0] x);
		logic [28:0] p;
		logic [28:0] p_sh;
		p    = 29'(x) * 29'(htc_pkg::DIV25_RECIP);
		p_sh = p >> htc_pkg::DIV25_SHIFT;
		return p_sh[8:0];
	endfunction

	always_comb begin
		w_ext      = {{23{temp_run_q[8]}}, temp_run_q};
		w_prod     = w_ext * 32'(htc_pkg::TEMP_UNIT);
		a_ext      = {{4{scaled.temp_num[27]}}, scaled.temp_num};
		t_diff     = a_ext - w_prod;
		t_diff_mag = t_diff[31] ? 32'(-t_diff) : 32'(t_diff);
		gate_t     = (t_diff_mag <= 32'(htc_pkg::TEMP_GATE)) || (temp_run_q == '0);

		// The mean of old value and reading, truncated: |sum| / 2^15 / 25.
		t_sum     = w_prod + a_ext;
		t_sum_mag = t_sum[31] ? 32'(-t_sum) : 32'(t_sum);
		qn_mag    = div25(t_sum_mag[27:15]);
		qn        = t_sum[31] ? -$signed({1'b0, qn_mag}) : $signed({1'b0, qn_mag});

		// From a zero start the mean with the truncated reading is that reading.
		a_mag  = a_ext[31] ? 32'(-a_ext) : 32'(a_ext);
		q0_mag = div25(a_mag[26:14]);
		q0     = a_ext[31] ? -$signed({1'b0, q0_mag}) : $signed({1'b0, q0_mag});

		t_new = (temp_run_q == '0) ? q0[8:0] : qn[8:0];

		h_wp       = {humid_run_q, 14'd0};
		h_diff     = $signed({3'd0, scaled.humid_num}) - $signed({2'd0, h_wp});
		h_diff_mag = h_diff[23] ? 24'(-h_diff) : 24'(h_diff);
		gate_h     = (h_diff_mag <= 24'(htc_pkg::HUM_GATE)) || (humid_run_q == '0);
		h_sum      = {1'b0, h_wp} + {2'd0, scaled.humid_num};
		h_new      = (humid_run_q == '0) ? {1'b0, scaled.humid_num[20:14]} : h_sum[22:15];

		run.op  = scaled.op;
		run.err = scaled.err;
		if (scaled.err) begin
			run.acc       = 1'b0;
			run.run_value = '0;
		end else if (scaled.op == htc_pkg::OP_TEMP) begin
			run.acc       = gate_t;
			run.run_value = gate_t ? t_new : temp_run_q;
		end else begin
			run.acc       = gate_h;
			run.run_value = {1'b0, gate_h ? h_new : humid_run_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_run_q  <= '0;
			humid_run_q <= '0;
		end else if (upd && run.acc) begin
			if (scaled.op == htc_pkg::OP_TEMP) begin
				temp_run_q <= t_new;
			end else begin
				humid_run_q <= h_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/htc_window_out.sv =====
`timescale 1ns / 1ps
`default_nettype none

module htc_window_out (
	input  logic                  clk,
	input  logic                  arst_n,
	input  htc_pkg::htc_run_t     run,
	input  logic                  upd,
	input  htc_pkg::htc_cfg_t     cfg,
	output htc_pkg::htc_result_t  res
);

	localparam int D      = htc_pkg::WINDOW_DEPTH;
	localparam int SW     = htc_pkg::SUM_W;
	localparam int PW     = SW + htc_pkg::MEAN_SHIFT;

	logic signed [8:0]  temp_win_q  [D];
	logic [7:0]         humid_win_q [D];
	logic signed [7:0]  temp_held_q;
	logic [6:0]         humid_held_q;

	logic signed [SW-1:0] t_sum;
	logic [SW-1:0]        t_sum_mag;
	logic [8:0]           t_mean_mag;
	logic signed [11:0]   t_avg;
	logic signed [11:0]   t_bias;
	logic signed [11:0]   t_cand;
	logic signed [7:0]    t_held_new;

	logic [SW-1:0]        h_sum;
	logic [8:0]           h_mean;
	logic [8:0]           h_corr;
	logic [9:0]           h_base;
	logic [9:0]           h_cand;
	logic [6:0]           h_held_new;

	logic                 push_t;
	logic                 push_h;

	function automatic logic [8:0] mean_floor(input logic [SW-1:0] x);
		logic [PW-1:0] p;
		logic [PW-1:0] p_sh;
		p    = PW'(x) * PW'(htc_pkg::MEAN_RECIP);
		p_sh = p >> htc_pkg::MEAN_SHIFT;
		return p_sh[8:0];
	endfunction

	always_comb begin
		t_sum = SW'(run.run_value);
		h_sum = SW'(run.run_value[7:0]);
		for (int i = 0; i < D - 1; i++) begin
			t_sum = t_sum + SW'(temp_win_q[i]);
			h_sum = h_sum + SW'(humid_win_q[i]);
		end

		t_sum_mag  = t_sum[SW-1] ? SW'(-t_sum) : SW'(t_sum);
		t_mean_mag = mean_floor(t_sum_mag);
		t_avg      = t_sum[SW-1] ? -$signed({3'd0, t_mean_mag}) : $signed({3'd0, t_mean_mag});
		t_bias     = $signed({4'd0, cfg.temp_bias});
		if (t_avg + 12'(htc_pkg::TEMP_KNEE) > t_bias) begin
			t_cand = t_avg + 12'(htc_pkg::BIAS_BASE) - t_bias;
		end else begin
			t_cand = 12'(htc_pkg::TEMP_LO);
		end
		priority if (t_cand >= 12'(htc_pkg::TEMP_HI)) begin
			t_held_new = 8'(htc_pkg::TEMP_HI);
		end else if (t_cand <= 12'(htc_pkg::TEMP_LO)) begin
			t_held_new = 8'(htc_pkg::TEMP_LO);
		end else begin
			t_held_new = t_cand[7:0];
		end

		h_mean = mean_floor(h_sum);
		h_corr = htc_pkg::HUM_CORR[h_mean[7:0]];
		h_base = {1'b0, h_corr} + 10'(htc_pkg::BIAS_BASE);
		h_cand = (h_base > {2'd0, cfg.humid_bias}) ? h_base - {2'd0, cfg.humid_bias} : '0;
		h_held_new = (h_cand >= 10'(htc_pkg::HUMID_HI)) ? 7'(htc_pkg::HUMID_HI) : h_cand[6:0];

		push_t = run.acc && (run.op == htc_pkg::OP_TEMP);
		push_h = run.acc && (run.op == htc_pkg::OP_HUMID);

		res.run_value    = run.run_value;
		res.sensor_error = run.err;
		res.accepted     = run.acc;
		if (run.err) begin
			res.temp_out  = '0;
			res.humid_out = '0;
		end else begin
			res.temp_out  = push_t ? t_held_new : temp_held_q;
			res.humid_out = push_h ? h_held_new : humid_held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < D; i++) begin
				temp_win_q[i]  <= '0;
				humid_win_q[i] <= '0;
			end
			temp_held_q  <= '0;
			humid_held_q <= '0;
		end else if (upd) begin
			temp_held_q  <= res.temp_out;
			humid_held_q <= res.humid_out;
			if (push_t) begin
				temp_win_q[0] <= run.run_value;
				for (int i = 1; i < D; i++) begin
					temp_win_q[i] <= temp_win_q[i-1];
				end
			end
			if (push_h) begin
				humid_win_q[0] <= run.run_value[7:0];
				for (int i = 1; i < D; i++) begin
					humid_win_q[i] <= humid_win_q[i-1];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/humidity_temperature_conditioner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Conditions raw temperature and humidity sensor words into held whole-degree and
// whole-percent readings. Each beat on the input stream carries one sensor word in
// s_axis_tdata and the channel in s_axis_tuser (0 temperature, 1 humidity); each
// produces exactly one result beat. The block takes one beat per cycle unless
// m_axis_tready stalls the output. Beats pass a scaling register, a running-value
// stage with a combinational spike gate and mean update, and the window/held-value
// stage feeding the output register. The user must write the calibration registers over
// the APB port only while no reading is in flight; the block does not enforce this.
module humidity_temperature_conditioner (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] raw_reading
	input  logic [0:0]  s_axis_tuser,   // [0] op

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] temp_out, [14:8] humid_out, [23:15] run_value
	output logic [1:0]  m_axis_tuser,   // [0] sensor_error, [1] accepted

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	htc_pkg::htc_cfg_t    cfg;
	htc_pkg::htc_scaled_t scaled;
	htc_pkg::htc_scaled_t scaled_s1;
	htc_pkg::htc_run_t    run;
	htc_pkg::htc_run_t    run_s2;
	htc_pkg::htc_result_t res;
	htc_pkg::htc_result_t res_q;

	logic valid_s1;
	logic valid_s2;
	logic out_valid_q;
	logic ready_s1;
	logic ready_s2;
	logic ready_out;

	assign ready_out = !out_valid_q || m_axis_tready;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;

	assign s_axis_tready = ready_s1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {res_q.run_value, res_q.humid_out, res_q.temp_out};
	assign m_axis_tuser  = {res_q.accepted, res_q.sensor_error};

	htc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	htc_scale u_scale (
		.op                (s_axis_tuser[0]),
		.raw_reading       (s_axis_tdata),
		.temp_offset_centi (cfg.temp_offset_centi),
		.scaled            (scaled)
	);

	htc_run_filter u_run (
		.clk    (clk),
		.arst_n (arst_n),
		.scaled (scaled_s1),
		.upd    (valid_s1 && ready_s2),
		.run    (run)
	);

	htc_window_out u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.run    (run_s2),
		.upd    (valid_s2 && ready_out),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && ready_s1) begin
			scaled_s1 <= scaled;
		end
		if (valid_s1 && ready_s2) begin
			run_s2 <= run;
		end
		if (valid_s2 && ready_out) begin
			res_q <= res;
		end
	end

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ready_out && run_s2.err) |=>
		(res_q.temp_out == '0 && res_q.humid_out == '0 && res_q.run_value == '0 &&
		 !res_q.accepted))
		else $error("error beat did not clear the held outputs");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		($signed(res_q.temp_out) >= -8'sd20 && $signed(res_q.temp_out) <= 8'sd100 &&
		 res_q.humid_out <= 7'd100))
		else $error("held output out of range");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with an empty output register");

endmodule

`default_nettype wire
